@@ hw/rtl/qctc_pkg.sv @@
// shared types and constants for the query challenge token checker
`default_nettype none

package qctc_pkg;

	// header checks
	localparam logic [15:0] MAGIC_VALID    = 16'hFEFD;
	localparam logic [7:0]  TYPE_HANDSHAKE = 8'd9;
	localparam logic [7:0]  TYPE_STAT      = 8'd0;
	localparam logic [15:0] MIN_LEN_ANY    = 16'd7;
	localparam logic [15:0] MIN_LEN_STAT   = 16'd11;
	localparam logic [15:0] MIN_LEN_FULL   = 16'd15;

	// configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TTL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd1;
	localparam logic [31:0] TTL_RESET  = 32'd30000;
	localparam logic [63:0] SEED_RESET = 64'd0;

	// token generator
	localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
	localparam logic [63:0] LCG_INC = 64'd1442695040888963407;
	localparam int unsigned TOK_LSB = 33;
	localparam int unsigned TOK_W   = 24;

	typedef enum logic [1:0] {
		ACT_DROP      = 2'd0,
		ACT_HANDSHAKE = 2'd1,
		ACT_BASIC     = 2'd2,
		ACT_FULL      = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		LCG_LO_LO,
		LCG_LO_HI,
		LCG_HI_LO,
		LCG_CROSS,
		LCG_ADD_INC
	} lcg_step_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG,
		ST_WALK,
		ST_APPEND,
		ST_FINISH
	} state_t;

	// one challenge table entry
	typedef struct packed {
		logic [47:0]      sender;
		logic [TOK_W-1:0] token;
		logic [47:0]      etime;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      lcg_en;
		lcg_step_t lcg_step;
		logic      walk_en;
		logic      append;
		logic      out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
		logic is_hs;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/qctc_if.sv @@
// channel interfaces: request beats, result beats and register writes
`default_nettype none

interface qctc_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] request_length;
	logic [15:0] magic;
	logic [7:0]  packet_type;
	logic [31:0] session_id;
	logic [31:0] request_token;
	logic [31:0] sender_ip;
	logic [15:0] sender_port;
	logic [47:0] now_ms;

	modport source (
		output valid, request_length, magic, packet_type, session_id,
		request_token, sender_ip, sender_port, now_ms,
		input ready
	);
	modport sink (
		input valid, request_length, magic, packet_type, session_id,
		request_token, sender_ip, sender_port, now_ms,
		output ready
	);
endinterface

interface qctc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] reply_session;
	logic [23:0] issued_token;

	modport source (output valid, action, reply_session, issued_token, input ready);
	modport sink (input valid, action, reply_session, issued_token, output ready);
endinterface

interface qctc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/qctc_ctrl.sv @@
// sequencing state machine: capture, token step, table scan, append, result
`default_nettype none

module qctc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output qctc_pkg::cmd_t     cmd,
	input  wire qctc_pkg::sts_t sts
);
	import qctc_pkg::*;

	state_t    state_q;
	state_t    state_nxt;
	lcg_step_t step_q;
	logic      out_valid_q;
	logic      out_free;

	// result register can take a new beat
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_LCG;
			end
			ST_LCG: begin
				if (step_q == LCG_ADD_INC) state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_done) state_nxt = sts.is_hs ? ST_APPEND : ST_FINISH;
			end
			ST_APPEND: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_LCG: begin
				cmd.lcg_en   = 1'b1;
				cmd.lcg_step = step_q;
			end
			ST_WALK: begin
				cmd.walk_en = 1'b1;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
			end
			ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state, generator step and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= LCG_LO_LO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_LCG && step_q != LCG_ADD_INC) begin
				step_q <= lcg_step_t'(3'(step_q + 3'd1));
			end else begin
				step_q <= LCG_LO_LO;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/qctc_dpath.sv @@
// datapath: request capture, token generator, challenge table memory and scan
`default_nettype none

module qctc_dpath #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	qctc_req_if.sink            req,
	qctc_rsp_if.source          rsp,
	qctc_cfg_if.sink            cfg,
	input  wire qctc_pkg::cmd_t cmd,
	output qctc_pkg::sts_t      sts
);
	import qctc_pkg::*;

	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

	function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] p);
		return (p == LAST_IDX) ? '0 : IW'(p + 1'b1);
	endfunction

	// captured request
	logic [15:0] len_q;
	logic [15:0] magic_q;
	logic [7:0]  ptype_q;
	logic [31:0] session_q;
	logic [31:0] rtoken_q;
	logic [47:0] sender_q;
	logic [47:0] now_q;

	// registers and generator
	logic [31:0] ttl_q;
	logic [63:0] gen_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [TOK_W-1:0] new_tok;

	// table bookkeeping
	entry_t          mem_q [TABLE_ENTRIES];
	entry_t          rd_data_s1;
	logic            s1_v_q;
	logic [IW-1:0]   base_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   rd_ptr_q;
	logic [IW-1:0]   wr_ptr_q;
	logic [CW-1:0]   rd_cnt_q;
	logic [CW-1:0]   wr_cnt_q;
	logic            hit_q;

	logic        hdr_ok;
	logic        is_hs;
	logic        is_stat;
	logic        rd_issue;
	logic [48:0] age;
	logic        expired;
	logic        same_sender;
	logic        tok_eq;
	logic        keep;
	logic        hit_now;
	logic        mem_we;
	entry_t      mem_wdata;

	// result register
	action_t     act;
	action_t     act_q;
	logic [31:0] rsess_q;
	logic [23:0] rtok_q;

	// request classification
	assign hdr_ok  = (len_q >= MIN_LEN_ANY) && (magic_q == MAGIC_VALID);
	assign is_hs   = hdr_ok && (ptype_q == TYPE_HANDSHAKE);
	assign is_stat = hdr_ok && (ptype_q == TYPE_STAT) && (len_q >= MIN_LEN_STAT);

	// capture request beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q     <= req.request_length;
			magic_q   <= req.magic;
			ptype_q   <= req.packet_type;
			session_q <= req.session_id;
			rtoken_q  <= req.request_token;
			sender_q  <= {req.sender_ip, req.sender_port};
			now_q     <= req.now_ms;
		end
	end

	// register writes and generator state
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
			gen_q <= SEED_RESET;
		end else begin
			if (cfg.valid && cfg.index == CFG_TTL) begin
				ttl_q <= cfg.data[31:0];
			end
			if (cfg.valid && cfg.index == CFG_SEED) begin
				gen_q <= cfg.data;
			end else if (cmd.out_load && is_hs) begin
				gen_q <= acc_q;
			end
		end
	end

	// shared 32x32 multiplier operands
	always_comb begin
		case (cmd.lcg_step)
			LCG_LO_HI: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MUL[63:32];
			end
			LCG_HI_LO: begin
				mul_a = gen_q[63:32];
				mul_b = LCG_MUL[31:0];
			end
			default: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MUL[31:0];
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign new_tok = acc_q[TOK_LSB +: TOK_W];

	// low product, then the two cross products into the upper half, then increment
	always_ff @(posedge clk) begin
		if (cmd.lcg_en) begin
			prod_q <= mul_p;
			case (cmd.lcg_step)
				LCG_LO_HI: acc_q <= prod_q;
				LCG_HI_LO: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				LCG_CROSS: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				LCG_ADD_INC: acc_q <= acc_q + LCG_INC;
				default: acc_q <= acc_q;
			endcase
		end
	end

	// per entry checks on the registered read beat
	assign rd_issue    = cmd.walk_en && (rd_cnt_q != count_q);
	assign age         = {1'b0, now_q} - {1'b0, rd_data_s1.etime};
	assign expired     = !age[48] && (age[47:0] >= {16'd0, ttl_q});
	assign same_sender = rd_data_s1.sender == sender_q;
	assign tok_eq      = (rtoken_q[31:TOK_W] == '0) && (rtoken_q[TOK_W-1:0] == rd_data_s1.token);
	assign keep        = s1_v_q && !expired && !(is_hs && same_sender);
	assign hit_now     = s1_v_q && !expired && is_stat && same_sender && tok_eq;

	// compaction write during the scan, new entry on append
	assign mem_we = keep || cmd.append;
	always_comb begin
		if (cmd.append) begin
			mem_wdata = '{sender: sender_q, token: new_tok, etime: now_q};
		end else begin
			mem_wdata = rd_data_s1;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[wr_ptr_q] <= mem_wdata;
		if (rd_issue) rd_data_s1 <= mem_q[rd_ptr_q];
	end

	// scan pointers and table occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q   <= 1'b0;
			base_q   <= '0;
			count_q  <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				s1_v_q   <= 1'b0;
				rd_ptr_q <= base_q;
				wr_ptr_q <= base_q;
				rd_cnt_q <= '0;
				wr_cnt_q <= '0;
				hit_q    <= 1'b0;
			end else begin
				s1_v_q <= rd_issue;
				if (rd_issue) begin
					rd_ptr_q <= idx_next(rd_ptr_q);
					rd_cnt_q <= CW'(rd_cnt_q + 1'b1);
				end
				if (keep) begin
					wr_ptr_q <= idx_next(wr_ptr_q);
					wr_cnt_q <= CW'(wr_cnt_q + 1'b1);
				end
				if (hit_now) hit_q <= 1'b1;
			end
			// full table: the new entry overwrites the oldest one
			if (cmd.append && wr_cnt_q == FULL_CNT) begin
				base_q <= idx_next(base_q);
			end
			if (cmd.out_load) begin
				if (is_hs) begin
					count_q <= (wr_cnt_q == FULL_CNT) ? FULL_CNT : CW'(wr_cnt_q + 1'b1);
				end else begin
					count_q <= wr_cnt_q;
				end
			end
		end
	end

	assign sts.walk_done = (rd_cnt_q == count_q) && !s1_v_q;
	assign sts.is_hs     = is_hs;

	// result selection
	always_comb begin
		if (is_hs) begin
			act = ACT_HANDSHAKE;
		end else if (is_stat && hit_q) begin
			act = (len_q >= MIN_LEN_FULL) ? ACT_FULL : ACT_BASIC;
		end else begin
			act = ACT_DROP;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			act_q   <= act;
			rsess_q <= (act != ACT_DROP) ? session_q : 32'd0;
			rtok_q  <= is_hs ? new_tok : '0;
		end
	end

	assign rsp.action        = act_q;
	assign rsp.reply_session = rsess_q;
	assign rsp.issued_token  = rtok_q;

endmodule

`default_nettype wire

@@ hw/rtl/query_challenge_token_checker.sv @@
// Query challenge token checker: one request beat in, one result beat out.
// An accepted request runs the 5-step token generator, a scan of the live entries
// and, for a handshake, an append; a new request is taken only after the result of
// the last one is loaded. The scan of the entry memory does one read, one write a
// cycle; the token generator runs on one 32x32 multiplier.
// Reset: table empty (fill count zero), ttl_ms = 30000, generator state 0.
`default_nettype none

module query_challenge_token_checker #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qctc_req_if.sink   req,
	qctc_rsp_if.source rsp,
	qctc_cfg_if.sink   cfg
);
	import qctc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;
	logic out_valid;

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

	// sequencer
	qctc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// table and generator datapath
	qctc_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

`default_nettype wire
